// ----- src/bgpw_pkg.sv -----
package bgpw_pkg;

    // glyph geometry and font store shape
    localparam int GLYPH_SIZE  = 8;
    localparam int ROW_W       = 3;
    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = 10;
    localparam int IDX_W       = STORE_AW - ROW_W;

    // draw queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 24;
    localparam logic [CFG_AW-1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_DRAW_COLOR    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_COLUMN_STRIDE = 2'd3;

    // command codes carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // pixel formats
    localparam logic [2:0] PF_RGBA8  = 3'd0;
    localparam logic [2:0] PF_BGR8   = 3'd1;
    localparam logic [2:0] PF_RGB565 = 3'd2;
    localparam logic [2:0] PF_RGB5A1 = 3'd3;
    localparam logic [2:0] PF_RGBA4  = 3'd4;

    // input word, char_code in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] y_pos;
        logic [9:0] x_pos;
        logic [7:0] row_bits;
        logic [2:0] glyph_row;
        logic [7:0] char_code;
    } in_word_t;

    // output word, byte_offset in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [2:0]  byte_count;
        logic [31:0] pixel_bytes;
        logic [21:0] byte_offset;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic [23:0] draw_color;
        logic [9:0]  screen_width;
        logic [11:0] column_stride;
    } cfg_t;

    // accepted draw waiting for the back end
    typedef struct packed {
        logic [IDX_W-1:0] glyph_idx;
        logic [9:0]       x_pos;
        logic [7:0]       y_pos;
    } draw_cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic back_idle;
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_SCAN
    } back_state_t;

    function automatic logic [31:0] pack_color(input logic [2:0] fmt, input logic [23:0] rgb);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [31:0] v;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        case (fmt)
            PF_RGBA8:  v = {r, g, b, 8'hFF};
            PF_BGR8:   v = {8'h00, r, g, b};
            PF_RGB565: v = {16'h0000, r[7:3], g[7:2], b[7:3]};
            PF_RGB5A1: v = {16'h0000, r[7:3], g[7:3], b[7:3], 1'b1};
            default:   v = {16'h0000, r[7:4], g[7:4], b[7:4], 4'hF};
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pixel_byte_count(input logic [2:0] fmt);
        logic [2:0] c;
        case (fmt)
            PF_RGBA8: c = 3'd4;
            PF_BGR8:  c = 3'd3;
            default:  c = 3'd2;
        endcase
        return c;
    endfunction

endpackage

// ----- src/bgpw_ram.sv -----
module bgpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bgpw_front.sv -----
module bgpw_front #(
    parameter int SCREEN_ROWS = 240,
    parameter int FIRST_CODE  = 0,
    parameter int LAST_CODE   = 127
) (
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [39:0]                      s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic [9:0]                       screen_width,
    input  bgpw_pkg::status_t                status,
    input  logic                             q_full,
    output logic                             q_push,
    output bgpw_pkg::draw_cmd_t              q_data,
    output logic                             ram_we,
    output logic [bgpw_pkg::STORE_AW-1:0]    ram_waddr,
    output logic [7:0]                       ram_wdata
);

    localparam logic [7:0] FIRST8 = 8'(FIRST_CODE);
    localparam logic [7:0] LAST8  = 8'(LAST_CODE);
    localparam logic [8:0] ROWS9  = 9'(SCREEN_ROWS);
    localparam logic [10:0] GLYPH11 = 11'(bgpw_pkg::GLYPH_SIZE);
    localparam logic [8:0]  GLYPH9  = 9'(bgpw_pkg::GLYPH_SIZE);

    bgpw_pkg::in_word_t w;
    logic               code_ok;
    logic               on_screen;
    logic               accept;
    logic [7:0]         code_diff;
    logic [bgpw_pkg::IDX_W-1:0] idx;

    assign w = bgpw_pkg::in_word_t'(s_axis_tdata);

    // classify the word
    assign code_ok   = (w.char_code >= FIRST8) && (w.char_code <= LAST8);
    assign code_diff = w.char_code - FIRST8;
    assign idx       = code_diff[bgpw_pkg::IDX_W-1:0];
    assign on_screen = ({1'b0, w.x_pos} + GLYPH11 <= {1'b0, screen_width})
                    && ({1'b0, w.y_pos} + GLYPH9 <= ROWS9);

    // loads wait until no draw is pending so the font is not changed under it
    always_comb begin
        if (s_axis_tuser == bgpw_pkg::CMD_DRAW) begin
            s_axis_tready = !q_full;
        end else begin
            s_axis_tready = status.queue_empty && status.back_idle;
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // font store write
    assign ram_we    = accept && (s_axis_tuser == bgpw_pkg::CMD_LOAD) && code_ok;
    assign ram_waddr = {idx, w.glyph_row};
    assign ram_wdata = w.row_bits;

    // draw hand-off
    assign q_push          = accept && (s_axis_tuser == bgpw_pkg::CMD_DRAW) && code_ok && on_screen;
    assign q_data.glyph_idx = idx;
    assign q_data.x_pos     = w.x_pos;
    assign q_data.y_pos     = w.y_pos;

endmodule

// ----- src/bgpw_queue.sv -----
module bgpw_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bgpw_pkg::draw_cmd_t push_data,
    input  logic                pop,
    output bgpw_pkg::draw_cmd_t head,
    output logic                not_empty,
    output logic                full
);

    localparam int QD = bgpw_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    bgpw_pkg::draw_cmd_t entries_reg [QD];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(QD));
    assign head      = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("draw queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> not_empty)
        else $error("draw queue underflow");

endmodule

// ----- src/bgpw_back.sv -----
module bgpw_back #(
    parameter int SCREEN_ROWS = 240
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bgpw_pkg::cfg_t                cfg,
    input  logic                          q_valid,
    input  bgpw_pkg::draw_cmd_t           q_head,
    output logic                          q_pop,
    output logic                          back_idle,
    output logic                          ram_re,
    output logic [bgpw_pkg::STORE_AW-1:0] ram_raddr,
    input  logic [7:0]                    ram_rdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam logic [7:0] ROW_TOP = 8'(SCREEN_ROWS - 1);
    localparam int         NG      = bgpw_pkg::GLYPH_SIZE;
    localparam logic [2:0] ROW_MAX = 3'(NG - 1);

    bgpw_pkg::back_state_t state_reg, state_next;
    logic [2:0]  arr_reg, arr_next;
    logic [2:0]  row_reg, row_next;
    logic [bgpw_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [21:0] xs_reg, xs_next;
    logic [9:0]  rterm_reg, rterm_next;
    logic [7:0]  rows_reg [NG];
    logic [7:0]  rows_next [NG];

    logic        m_valid_reg;
    logic [21:0] m_off_reg;
    logic [31:0] m_bytes_reg;
    logic [2:0]  m_cnt_reg;
    logic        m_last_reg;

    logic [2:0]  count;
    logic [31:0] bytes;
    logic [7:0]  cur_pat;
    logic [7:0]  cleared;
    logic [2:0]  col;
    logic        rest_nz;
    logic        out_free;
    logic        emit;
    logic        emit_last;
    logic [14:0] col_term;
    logic [21:0] pix_off;
    logic [7:0]  row_base;
    bgpw_pkg::out_word_t ow;

    assign count    = bgpw_pkg::pixel_byte_count(cfg.pixel_format);
    assign bytes    = bgpw_pkg::pack_color(cfg.pixel_format, cfg.draw_color);
    assign cur_pat  = rows_reg[row_reg];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign row_base = ROW_TOP - q_head.y_pos;

    // lowest lit column of the current row
    always_comb begin
        logic found;
        found = 1'b0;
        col   = 3'd0;
        for (int k = 0; k < NG; k++) begin
            if (!found && cur_pat[k]) begin
                col   = 3'(k);
                found = 1'b1;
            end
        end
    end

    assign cleared = cur_pat & ~(8'd1 << col);

    // any lit bit left in the rows below the current one
    always_comb begin
        rest_nz = 1'b0;
        for (int k = 0; k < NG; k++) begin
            if (3'(k) > row_reg) begin
                rest_nz = rest_nz | (|rows_reg[k]);
            end
        end
    end

    // pixel address
    assign col_term = 15'(col) * 15'(cfg.column_stride);
    assign pix_off  = xs_reg + 22'(col_term) + 22'(rterm_reg);

    // sequencer: pop, fetch eight glyph rows, scan lit bits
    always_comb begin
        state_next = state_reg;
        arr_next   = arr_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        xs_next    = xs_reg;
        rterm_next = rterm_reg;
        rows_next  = rows_reg;
        q_pop      = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = {idx_reg, arr_reg + 3'd1};
        emit       = 1'b0;
        emit_last  = 1'b0;
        case (state_reg)
            bgpw_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = {q_head.glyph_idx, 3'd0};
                    idx_next   = q_head.glyph_idx;
                    arr_next   = 3'd0;
                    row_next   = 3'd0;
                    xs_next    = 22'(q_head.x_pos) * 22'(cfg.column_stride);
                    rterm_next = 10'(row_base) * 10'(count);
                    state_next = bgpw_pkg::B_FETCH;
                end
            end
            bgpw_pkg::B_FETCH: begin
                rows_next[arr_reg] = ram_rdata;
                if (arr_reg == ROW_MAX) begin
                    state_next = bgpw_pkg::B_SCAN;
                end else begin
                    ram_re   = 1'b1;
                    arr_next = arr_reg + 3'd1;
                end
            end
            bgpw_pkg::B_SCAN: begin
                if (cur_pat == 8'd0) begin
                    if (!rest_nz) begin
                        state_next = bgpw_pkg::B_IDLE;
                    end else begin
                        row_next   = row_reg + 3'd1;
                        rterm_next = rterm_reg - 10'(count);
                    end
                end else if (out_free) begin
                    emit              = 1'b1;
                    emit_last         = (cleared == 8'd0) && !rest_nz;
                    rows_next[row_reg] = cleared;
                    if (emit_last) begin
                        state_next = bgpw_pkg::B_IDLE;
                    end
                end
            end
            default: begin
                state_next = bgpw_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bgpw_pkg::B_IDLE;
            arr_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            arr_reg   <= arr_next;
            row_reg   <= row_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working data and output word
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        xs_reg    <= xs_next;
        rterm_reg <= rterm_next;
        rows_reg  <= rows_next;
        if (emit) begin
            m_off_reg   <= pix_off;
            m_bytes_reg <= bytes;
            m_cnt_reg   <= count;
            m_last_reg  <= emit_last;
        end
    end

    assign back_idle      = (state_reg == bgpw_pkg::B_IDLE);
    assign ow.pad         = '0;
    assign ow.byte_count  = m_cnt_reg;
    assign ow.pixel_bytes = m_bytes_reg;
    assign ow.byte_offset = m_off_reg;
    assign m_axis_tdata   = ow;
    assign m_axis_tvalid  = m_valid_reg;
    assign m_axis_tlast   = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == bgpw_pkg::B_FETCH)
        else $error("pop did not start a glyph fetch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> state_reg == bgpw_pkg::B_SCAN && cur_pat != 8'd0)
        else $error("pixel emitted outside the scan of a lit row");

endmodule

// ----- src/bitmap_glyph_pixel_writer.sv -----
// channel   dir  ports                            contents
// s_axis    in   tvalid tready tdata[39:0] tuser  load glyph row / draw character
// m_axis    out  tvalid tready tdata[63:0] tlast  one pixel store per lit glyph bit
// cfg       in   cfg_we cfg_addr cfg_wdata        pixel format, color, width, stride
//
// a load word is taken only when no draw is pending
// a draw is popped from the queue, then reads its eight rows from the font store
// over the single read port, then scans them for one pixel store per lit bit, stepping
// over empty rows and holding while m_axis_tready is low; up to two further draws wait in the queue
// reset (aresetn low, synchronous) empties the queue and the output register;
// the font store is not cleared; the output register holds a word while m_axis_tready is low
module bitmap_glyph_pixel_writer #(
    parameter int SCREEN_ROWS = 240,
    parameter int FIRST_CODE  = 0,
    parameter int LAST_CODE   = 127
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // char_code[7:0], glyph_row[10:8], row_bits[18:11], x_pos[28:19], y_pos[36:29], zero pad
    input  logic [39:0]                   s_axis_tdata,
    // cmd
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // byte_offset[21:0], pixel_bytes[53:22], byte_count[56:54], zero pad
    output logic [63:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          cfg_we,
    input  logic [bgpw_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [bgpw_pkg::CFG_DW-1:0]   cfg_wdata
);

    bgpw_pkg::cfg_t      cfg_reg;
    bgpw_pkg::status_t   status;
    bgpw_pkg::draw_cmd_t q_push_data;
    bgpw_pkg::draw_cmd_t q_head;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    logic q_full;
    logic back_idle;
    logic ram_we;
    logic [bgpw_pkg::STORE_AW-1:0] ram_waddr;
    logic [7:0] ram_wdata;
    logic ram_re;
    logic [bgpw_pkg::STORE_AW-1:0] ram_raddr;
    logic [7:0] ram_rdata;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format  <= bgpw_pkg::PF_RGBA8;
            cfg_reg.draw_color    <= 24'hFFFFFF;
            cfg_reg.screen_width  <= 10'd400;
            cfg_reg.column_stride <= 12'd720;
        end else if (cfg_we) begin
            case (cfg_addr)
                bgpw_pkg::CFG_PIXEL_FORMAT:  cfg_reg.pixel_format  <= cfg_wdata[2:0];
                bgpw_pkg::CFG_DRAW_COLOR:    cfg_reg.draw_color    <= cfg_wdata;
                bgpw_pkg::CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wdata[9:0];
                bgpw_pkg::CFG_COLUMN_STRIDE: cfg_reg.column_stride <= cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    assign status.queue_empty = !q_not_empty;
    assign status.back_idle   = back_idle;

    bgpw_front #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .FIRST_CODE  (FIRST_CODE),
        .LAST_CODE   (LAST_CODE)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .screen_width  (cfg_reg.screen_width),
        .status        (status),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    bgpw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    bgpw_ram #(
        .WIDTH (8),
        .DEPTH (bgpw_pkg::STORE_DEPTH)
    ) u_font (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bgpw_back #(
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .back_idle     (back_idle),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> q_not_empty == 1'b0 && back_idle)
        else $error("font row written while a draw was pending");

endmodule
